>>> design/pehs_pkg.sv
// Package for the periodic event heap scheduler.
// Holds the action and status codes, the controller state type and the command/status structs.
// No dependencies.
package pehs_pkg;

  typedef enum logic [1:0] {
    ACT_REGISTER = 2'd0,
    ACT_NEXT     = 2'd1,
    ACT_CLEAR    = 2'd2,
    ACT_NONE     = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RD_ROOT,
    S_RD_LAST,
    S_LD_MOV,
    S_DN_RD_L,
    S_DN_RD_R,
    S_DN_CMP,
    S_DN_WR,
    S_UP_START,
    S_UP_RD,
    S_UP_CMP,
    S_UP_WR,
    S_RESULT
  } state_e;

  localparam int unsigned ENTRY_W = 64;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_item;   // capture input beat
    logic rd_root;     // read slot 0
    logic rd_last;     // latch root as top, read slot count-1, dec count
    logic ld_mov;      // latch last entry as moving entry
    logic rd_left;     // read left child
    logic rd_right;    // latch left child, read right child
    logic dn_step;     // move best child up when it beats the moving entry
    logic dn_final;    // write moving entry at position
    logic up_start;    // prepare insert of new entry
    logic rd_parent;   // read parent
    logic up_step;     // move parent down when the moving entry beats it
    logic up_final;    // write entry at position
    logic clear;       // empty heap
    logic set_full;    // status full
    logic set_empty;   // status empty
    logic emit;        // present result
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic    full;
    logic    empty;
    logic    has_left;
    logic    dn_move;
    logic    up_root;
    logic    up_move;
    logic    out_busy;
    action_e action;
  } stat_t;

endpackage

>>> design/pehs_if.sv
// Valid/ready channel interfaces for the scheduler.
// Depends on nothing outside this file.
interface pehs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] source_id;
  logic [15:0] period;
  modport source (output valid, action, source_id, period, input ready);
  modport sink   (input valid, action, source_id, period, output ready);
endinterface

interface pehs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] event_id;
  logic [31:0] event_time;
  logic [1:0]  status;
  modport source (output valid, event_id, event_time, status, input ready);
  modport sink   (input valid, event_id, event_time, status, output ready);
endinterface

>>> design/pehs_datapath.sv
// Datapath: heap memory, position/count registers, key compare and output register.
// Depends on pehs_pkg and pehs_if.
module pehs_datapath
  import pehs_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output stat_t            stat_o,
  pehs_in_if.sink          in_if,
  pehs_out_if.source       out_if,
  input  logic             in_ready_i
);
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [ENTRY_W-1:0] mem [CAPACITY];
  logic [ENTRY_W-1:0] rd_q;
  logic               re, we;
  logic [AW-1:0]      ra, wa;
  logic [ENTRY_W-1:0] wd;

  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      pos_q, pos_d;
  logic [ENTRY_W-1:0] mov_q, mov_d;   // entry being sifted
  logic [ENTRY_W-1:0] top_q, top_d;   // removed top
  logic [ENTRY_W-1:0] lft_q, lft_d;   // left child
  action_e            act_q;
  logic [15:0]        sid_q, per_q;
  status_e            res_st_q;
  logic               ov_q;
  logic [15:0]        oid_q;
  logic [31:0]        otime_q;
  status_e            ost_q;

  logic [CW:0]        lidx, ridx;
  logic [CW-1:0]      parent;
  logic               has_left, has_right;
  logic [ENTRY_W-1:0] best;
  logic [CW-1:0]      best_idx;
  logic               dn_move, up_move;
  logic [32:0]        nsum;
  logic [31:0]        ntime;

  assign lidx   = {pos_q, 1'b1};
  assign ridx   = lidx + (CW+1)'(1);
  assign parent = (pos_q - CW'(1)) >> 1;
  assign nsum   = {1'b0, top_q[63:32]} + 33'(top_q[15:0]);
  assign ntime  = nsum[32] ? 32'hFFFF_FFFF : nsum[31:0];

  // Child choice and key compares; left wins a tie
  assign has_left  = (lidx < {1'b0, count_q});
  assign has_right = (ridx < {1'b0, count_q});
  always_comb begin
    if (has_right && (rd_q[63:16] < lft_q[63:16])) begin
      best = rd_q; best_idx = CW'(ridx);
    end else begin
      best = lft_q; best_idx = CW'(lidx);
    end
  end
  assign dn_move = (best[63:16] < mov_q[63:16]);
  assign up_move = (mov_q[63:16] < rd_q[63:16]);

  // Memory port control
  always_comb begin
    re = 1'b0; ra = '0; we = 1'b0; wa = AW'(pos_q); wd = mov_q;
    if (cmd_i.rd_root) begin
      re = 1'b1; ra = '0;
    end else if (cmd_i.rd_last) begin
      re = 1'b1; ra = AW'(count_q - CW'(1));
    end else if (cmd_i.rd_left) begin
      re = 1'b1; ra = AW'(lidx);
    end else if (cmd_i.rd_right) begin
      re = has_right; ra = AW'(ridx);
    end else if (cmd_i.rd_parent) begin
      re = 1'b1; ra = AW'(parent);
    end
    if (cmd_i.dn_step && dn_move) begin
      we = 1'b1; wd = best;
    end else if (cmd_i.up_step && up_move) begin
      we = 1'b1; wd = rd_q;
    end else if (cmd_i.dn_final || cmd_i.up_final) begin
      we = 1'b1; wd = mov_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    if (re) rd_q <= mem[ra];
  end

  // Sift bookkeeping
  always_comb begin
    count_d = count_q; pos_d = pos_q;
    mov_d = mov_q; top_d = top_q; lft_d = lft_q;
    if (cmd_i.clear) count_d = '0;
    if (cmd_i.rd_last) begin
      top_d   = rd_q;
      count_d = count_q - CW'(1);
      pos_d   = '0;
    end
    if (cmd_i.ld_mov) mov_d = rd_q;
    // left child arrives while the right one is read
    if (cmd_i.rd_right) lft_d = rd_q;
    if (cmd_i.dn_step && dn_move) pos_d = best_idx;
    if (cmd_i.up_start) begin
      pos_d = count_q; count_d = count_q + CW'(1);
      if (act_q == ACT_REGISTER) mov_d = {16'h0, per_q, sid_q, per_q};
      else mov_d = {ntime, top_q[31:0]};
    end
    if (cmd_i.up_step && up_move) pos_d = parent;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) count_q <= '0;
    else count_q <= count_d;
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d; mov_q <= mov_d; top_q <= top_d; lft_q <= lft_d;
  end

  // Input beat and result status
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      act_q <= action_e'(in_if.action); sid_q <= in_if.source_id; per_q <= in_if.period;
      res_st_q <= ST_OK;
    end else if (cmd_i.set_full) begin
      res_st_q <= ST_FULL;
    end else if (cmd_i.set_empty) begin
      res_st_q <= ST_EMPTY;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (cmd_i.emit) ov_q <= 1'b1;
    else if (out_if.ready) ov_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (res_st_q != ST_OK) begin
        oid_q <= '0; otime_q <= '0; ost_q <= res_st_q;
      end else if (act_q == ACT_NEXT) begin
        oid_q <= top_q[31:16]; otime_q <= top_q[63:32]; ost_q <= ST_OK;
      end else begin
        oid_q <= '0; otime_q <= '0; ost_q <= ST_OK;
      end
    end
  end

  assign out_if.valid      = ov_q;
  assign out_if.event_id   = oid_q;
  assign out_if.event_time = otime_q;
  assign out_if.status     = ost_q;
  assign in_if.ready       = in_ready_i;

  assign stat_o.full      = (count_q >= CW'(CAPACITY));
  assign stat_o.empty     = (count_q == '0);
  assign stat_o.has_left  = has_left;
  assign stat_o.dn_move   = dn_move;
  assign stat_o.up_root   = (pos_q == '0);
  assign stat_o.up_move   = up_move;
  assign stat_o.out_busy  = ov_q && !out_if.ready;
  assign stat_o.action    = act_q;

`ifndef SYNTHESIS
  a_count_le_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY)) else $error("heap count beyond capacity");
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> count_q == '0) else $error("clear did not empty heap");
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(we && re)) else $error("read and write in one cycle");
  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_if.ready) |=> (ov_q && $stable({oid_q, otime_q, ost_q})))
    else $error("result beat changed while stalled");
`endif
endmodule

>>> design/periodic_event_heap_scheduler.sv
// Periodic event heap scheduler: a binary min-heap of periodic sources held in a
// single-port memory with registered read data (one read or one write a cycle).
// One input beat is worked at a time and gives exactly one result beat; the input
// is ready only while the controller is idle, which it enters at the edge that
// loads the previous result into the output register. Clear, the ignored action,
// register on a full heap and next on an empty heap go straight from the decode to
// the result; register climbs the new entry up level by level; next decodes, reads
// the root and the last entry, sifts the last entry down until there is no left
// child or a compare stops it (skipped when the heap held one entry), then
// reinserts the removed top with its next time by a climb, and emits the result.
// A stalled result holds the controller until the output register frees.
// No clearing pass is needed after reset. This file also holds the controller;
// it depends on pehs_pkg, pehs_if and pehs_datapath.
module periodic_event_heap_scheduler
  import pehs_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pehs_in_if.sink     in_if,
  pehs_out_if.source  out_if
);
  cmd_t  cmd;
  stat_t stat;
  logic  rdy;

  pehs_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(in_if.valid), .stat_i(stat),
    .cmd_o(cmd), .in_ready_o(rdy)
  );

  pehs_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .in_if(in_if), .out_if(out_if), .in_ready_i(rdy)
  );
endmodule

// Controller: sequences decode, sift down and sift up, one beat at a time
module pehs_ctrl
  import pehs_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  in_ready_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        case (stat_i.action)
          ACT_REGISTER: state_d = stat_i.full ? S_RESULT : S_UP_START;
          ACT_NEXT:     state_d = stat_i.empty ? S_RESULT : S_RD_ROOT;
          default:      state_d = S_RESULT;
        endcase
      end
      S_RD_ROOT:  state_d = S_RD_LAST;
      S_RD_LAST:  state_d = S_LD_MOV;
      // heap held a single entry: nothing to sift down
      S_LD_MOV:   state_d = stat_i.empty ? S_UP_START : S_DN_RD_L;
      S_DN_RD_L:  state_d = stat_i.has_left ? S_DN_RD_R : S_DN_WR;
      S_DN_RD_R:  state_d = S_DN_CMP;
      S_DN_CMP:   state_d = stat_i.dn_move ? S_DN_RD_L : S_DN_WR;
      S_DN_WR:    state_d = S_UP_START;
      S_UP_START: state_d = S_UP_RD;
      S_UP_RD:    state_d = stat_i.up_root ? S_UP_WR : S_UP_CMP;
      S_UP_CMP:   state_d = stat_i.up_move ? S_UP_RD : S_UP_WR;
      S_UP_WR:    state_d = S_RESULT;
      S_RESULT: begin
        if (!stat_i.out_busy) state_d = S_IDLE;
      end
      default:    state_d = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load_item = in_valid_i;
      end
      S_DECODE: begin
        case (stat_i.action)
          ACT_REGISTER: cmd_o.set_full = stat_i.full;
          ACT_NEXT:     cmd_o.set_empty = stat_i.empty;
          ACT_CLEAR:    cmd_o.clear = 1'b1;
          default: ;
        endcase
      end
      S_RD_ROOT:  cmd_o.rd_root = 1'b1;
      S_RD_LAST:  cmd_o.rd_last = 1'b1;
      S_LD_MOV:   cmd_o.ld_mov = 1'b1;
      S_DN_RD_L:  cmd_o.rd_left = stat_i.has_left;
      S_DN_RD_R:  cmd_o.rd_right = 1'b1;
      S_DN_CMP:   cmd_o.dn_step = 1'b1;
      S_DN_WR:    cmd_o.dn_final = 1'b1;
      S_UP_START: cmd_o.up_start = 1'b1;
      S_UP_RD:    cmd_o.rd_parent = !stat_i.up_root;
      S_UP_CMP:   cmd_o.up_step = 1'b1;
      S_UP_WR:    cmd_o.up_final = 1'b1;
      S_RESULT:   cmd_o.emit = !stat_i.out_busy;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == S_IDLE) else $error("input ready outside idle");
  a_emit_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> !stat_i.out_busy) else $error("result emitted over a waiting beat");
  a_state_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown(state_q)) else $error("controller state unknown");
`endif
endmodule
